FILE: design/mrh_pkg.sv
// ----------------------------------------------------------------------------
// mrh_pkg
// Shared types, constants and the mod 2^61-1 fold for the rolling hash table.
// ----------------------------------------------------------------------------
package mrh_pkg;

  localparam int HASH_W    = 61;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int CMD_W     = 2;
  localparam int ACC_W     = 64;
  localparam int PROD_W    = 62;
  localparam int HALF_LO_W = 31;
  localparam int HALF_HI_W = 30;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 64;

  localparam logic [HASH_W-1:0] HASH_MOD   = {HASH_W{1'b1}};
  localparam logic [HASH_W-1:0] BASE_RESET = 61'd1000000007;
  localparam logic [HASH_W-1:0] POW_ZERO   = 61'd1;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // register index taken from the top address bit
  localparam logic REG_HASH_BASE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_QLOAD,
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } mrh_state_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mrh_mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [HASH_W-1:0] value;
  } mrh_mul_rsp_t;

  // Reduce a 64-bit value to [0, P), P = 2^61-1.
  function automatic logic [HASH_W-1:0] fold_mod(input logic [ACC_W-1:0] v);
    logic [HASH_W:0] s;
    s = {1'b0, v[HASH_W-1:0]} + (HASH_W+1)'(v[ACC_W-1:HASH_W]);
    if (s >= {1'b0, HASH_MOD}) begin
      s = s - {1'b0, HASH_MOD};
    end
    return s[HASH_W-1:0];
  endfunction

endpackage

FILE: design/mrh_if.sv
// ----------------------------------------------------------------------------
// mrh_if
// Valid/ready channels: command items in, hash result items out.
// ----------------------------------------------------------------------------
interface mrh_in_if;
  import mrh_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  left_index;
  logic [IDX_W-1:0]  right_index;

  modport source (output valid, command, char_code, left_index, right_index, input ready);
  modport sink   (input valid, command, char_code, left_index, right_index, output ready);
endinterface

interface mrh_out_if;
  import mrh_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;
  logic              range_error;

  modport source (output valid, hash_value, range_error, input ready);
  modport sink   (input valid, hash_value, range_error, output ready);
endinterface

FILE: design/mrh_ram.sv
// ----------------------------------------------------------------------------
// mrh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrh_ram #(
  parameter int WIDTH = 61,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mrh_mulmod.sv
// ----------------------------------------------------------------------------
// mrh_mulmod
// a*b mod 2^61-1 on one 31x31 multiplier: four partial products, then fold.
// ----------------------------------------------------------------------------
module mrh_mulmod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mrh_pkg::mrh_mul_req_t req,
  output mrh_pkg::mrh_mul_rsp_t rsp
);
  import mrh_pkg::*;

  localparam int STEP_W    = 3;
  localparam int MID_SPLIT = HALF_HI_W;
  localparam logic [STEP_W-1:0] STEP_LAST_PP = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FOLD    = 3'd5;

  // partial product kinds
  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_LH = 2'd1;
  localparam logic [1:0] PP_HL = 2'd2;
  localparam logic [1:0] PP_HH = 2'd3;

  logic [HASH_W-1:0]    a_r;
  logic [HASH_W-1:0]    b_r;
  logic [STEP_W-1:0]    step_r;
  logic                 run_r;
  logic                 pv_r;
  logic                 done_r;
  logic [1:0]           pk_r;
  logic [PROD_W-1:0]    prod_r;
  logic [ACC_W-1:0]     acc_r;
  logic [HASH_W-1:0]    res_r;
  logic [HALF_LO_W-1:0] mul_x;
  logic [HALF_LO_W-1:0] mul_y;
  logic [ACC_W-1:0]     term;

  always_comb begin
    unique case (step_r[1:0])
      PP_LL: begin
        mul_x = a_r[HALF_LO_W-1:0];
        mul_y = b_r[HALF_LO_W-1:0];
      end
      PP_LH: begin
        mul_x = a_r[HALF_LO_W-1:0];
        mul_y = {1'b0, b_r[HASH_W-1:HALF_LO_W]};
      end
      PP_HL: begin
        mul_x = {1'b0, a_r[HASH_W-1:HALF_LO_W]};
        mul_y = b_r[HALF_LO_W-1:0];
      end
      PP_HH: begin
        mul_x = {1'b0, a_r[HASH_W-1:HALF_LO_W]};
        mul_y = {1'b0, b_r[HASH_W-1:HALF_LO_W]};
      end
    endcase
  end

  // weight 2^62 folds to 2, weight 2^31 splits around bit 61
  always_comb begin
    unique case (pk_r)
      PP_LL:        term = ACC_W'(prod_r);
      PP_LH, PP_HL: term = ACC_W'(prod_r[PROD_W-1:MID_SPLIT])
                         + ACC_W'({prod_r[MID_SPLIT-1:0], {HALF_LO_W{1'b0}}});
      PP_HH:        term = ACC_W'({prod_r, 1'b0});
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        pv_r   <= 1'b0;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + STEP_W'(1);
        pv_r   <= (step_r <= STEP_LAST_PP);
        if (step_r == STEP_FOLD) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (run_r) begin
      if (step_r <= STEP_LAST_PP) begin
        prod_r <= PROD_W'(mul_x) * PROD_W'(mul_y);
        pk_r   <= step_r[1:0];
      end
      if (pv_r) begin
        acc_r <= acc_r + term;
      end
      if (step_r == STEP_FOLD) begin
        res_r <= fold_mod(acc_r);
      end
    end
  end

  assign rsp.busy  = run_r;
  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

FILE: design/mersenne_rolling_hash_table.sv
// ----------------------------------------------------------------------------
// mersenne_rolling_hash_table
// Polynomial rolling hash mod 2^61-1 over a byte string, with substring query.
// ----------------------------------------------------------------------------
// Each item carries a command. Append adds char_code to the string and
// returns the new whole-prefix hash h*B+c mod 2^61-1; query returns the hash
// of [left_index, right_index) as prefix[right] - prefix[left]*B^(right-left);
// clear empties the string. A bad query range or an append on a full string
// returns zero with range_error set; clear and the unused code return zero.
// B is the hash_base register (APB, byte address 0, 64-bit data, resets to
// 1000000007); write it only while the block is idle. Prefix hashes and base
// powers live in two RAMs; entry zero of each is a constant, so there is no
// clearing pass after reset. Items are handled one at a time. A good append
// runs two products in a row on the shared modular multiplier, a good query
// one and anything else none; each product is four 31x31 partial products, an
// accumulate and a fold. The result register lets the next item enter
// while a result waits.
// ----------------------------------------------------------------------------
module mersenne_rolling_hash_table #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mrh_in_if.sink                        in_ch,
  mrh_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrh_pkg::PADDR_W-1:0]   paddr,
  input  logic [mrh_pkg::PDATA_W-1:0]   pwdata,
  output logic [mrh_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mrh_pkg::*;

  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int CW    = (LEN_W > IDX_W) ? LEN_W : IDX_W;
  localparam int DEPTH = MAX_LENGTH + 1;
  localparam logic [LEN_W-1:0] MAX_LEN_C = LEN_W'(MAX_LENGTH);

  mrh_state_t        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [CHAR_W-1:0] ch_r;
  logic [IDX_W-1:0]  left_r;
  logic [IDX_W-1:0]  right_r;
  logic [LEN_W-1:0]  len_r;
  logic [HASH_W-1:0] base_r;
  logic [HASH_W-1:0] aux_r;
  logic [HASH_W-1:0] hash_r;
  logic              err_r;
  logic              p_zero_r;
  logic              w_zero_r;
  logic              out_valid_r;
  logic [HASH_W-1:0] out_hash_r;
  logic              out_err_r;

  mrh_mul_req_t      mreq;
  mrh_mul_rsp_t      mrsp;

  logic [LEN_W-1:0]  p_raddr;
  logic [LEN_W-1:0]  w_raddr;
  logic [LEN_W-1:0]  waddr;
  logic              we;
  logic [HASH_W-1:0] p_rdata;
  logic [HASH_W-1:0] w_rdata;
  logic [HASH_W-1:0] p_rd;
  logic [HASH_W-1:0] w_rd;
  logic [HASH_W-1:0] b_use;

  logic [CW-1:0]     left_x;
  logic [CW-1:0]     right_x;
  logic [CW-1:0]     len_x;
  logic [CW-1:0]     dist_x;
  logic              q_ok;
  logic              full;
  logic              in_acc;
  logic              out_load;
  logic              cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration: hash_base, stored masked, 2^61-1 acts as zero on use
  // --------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_HASH_BASE);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_HASH_BASE) ? PDATA_W'(base_r) : '0;
  assign b_use  = (base_r == HASH_MOD) ? '0 : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_wr) begin
      base_r <= pwdata[HASH_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Decode of the held item
  // --------------------------------------------------------------------------
  assign left_x  = CW'(left_r);
  assign right_x = CW'(right_r);
  assign len_x   = CW'(len_r);
  assign dist_x  = right_x - left_x;
  assign q_ok    = (left_x <= right_x) && (right_x <= len_x);
  assign full    = (len_r == MAX_LEN_C);
  assign waddr   = len_r + LEN_W'(1);

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // entry zero of each store is a constant and is never written
  assign p_rd = p_zero_r ? '0 : p_rdata;
  assign w_rd = w_zero_r ? POW_ZERO : w_rdata;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (cmd_r)
          CMD_APPEND: state_nxt = full ? ST_DONE : ST_LOAD;
          CMD_QUERY:  state_nxt = q_ok ? ST_QLOAD : ST_DONE;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_QLOAD: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MUL1;
      ST_MUL1: begin
        if (mrsp.done) state_nxt = (cmd_r == CMD_APPEND) ? ST_MUL2 : ST_DONE;
      end
      ST_MUL2: begin
        if (mrsp.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: RAM addresses, multiplier requests, write-back
  // --------------------------------------------------------------------------
  always_comb begin
    p_raddr = len_r;
    w_raddr = len_r;
    mreq    = '0;
    we      = 1'b0;
    unique case (state_r)
      ST_DECODE: begin
        // query: prefix[right] first, power[right-left] held through DECODE and QLOAD
        if (cmd_r == CMD_QUERY) begin
          p_raddr = right_x[LEN_W-1:0];
          w_raddr = dist_x[LEN_W-1:0];
        end
      end
      ST_QLOAD: begin
        p_raddr = left_x[LEN_W-1:0];
        w_raddr = dist_x[LEN_W-1:0];
      end
      ST_LOAD: begin
        mreq.start = 1'b1;
        mreq.a     = p_rd;
        mreq.b     = (cmd_r == CMD_QUERY) ? w_rd : b_use;
      end
      ST_MUL1: begin
        // append: next power right after the prefix product
        if (mrsp.done && (cmd_r == CMD_APPEND)) begin
          mreq.start = 1'b1;
          mreq.a     = aux_r;
          mreq.b     = b_use;
        end
      end
      ST_MUL2: begin
        we = mrsp.done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_DECODE) && (cmd_r == CMD_CLEAR)) begin
        len_r <= '0;
      end else if (we) begin
        len_r <= waddr;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    p_zero_r <= (p_raddr == '0);
    w_zero_r <= (w_raddr == '0);
    if (in_acc) begin
      cmd_r   <= in_ch.command;
      ch_r    <= in_ch.char_code;
      left_r  <= in_ch.left_index;
      right_r <= in_ch.right_index;
    end
    unique case (state_r)
      ST_DECODE: begin
        hash_r <= '0;
        err_r  <= ((cmd_r == CMD_APPEND) && full) || ((cmd_r == CMD_QUERY) && !q_ok);
      end
      ST_QLOAD: aux_r <= p_rd;
      ST_LOAD: begin
        if (cmd_r == CMD_APPEND) aux_r <= w_rd;
      end
      ST_MUL1: begin
        if (mrsp.done) begin
          if (cmd_r == CMD_APPEND) begin
            hash_r <= fold_mod(ACC_W'(mrsp.value) + ACC_W'(ch_r));
          end else begin
            hash_r <= fold_mod(ACC_W'(aux_r) + ACC_W'(HASH_MOD) - ACC_W'(mrsp.value));
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_hash_r <= hash_r;
      out_err_r  <= err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hash_value  = out_hash_r;
  assign out_ch.range_error = out_err_r;

  // --------------------------------------------------------------------------
  // Stores and the shared multiplier
  // --------------------------------------------------------------------------
  mrh_ram #(
    .WIDTH (HASH_W),
    .DEPTH (DEPTH)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (hash_r),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  mrh_ram #(
    .WIDTH (HASH_W),
    .DEPTH (DEPTH)
  ) u_power_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (mrsp.value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mrh_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= MAX_LEN_C)
    else $error("string length beyond store depth");

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.start && mrsp.busy))
    else $error("multiplier started while busy");

  a_write_append: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> ((cmd_r == CMD_APPEND) && !full))
    else $error("store written outside a non-full append");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished item not presented");
`endif

endmodule

FILE: verif/tb_mersenne_rolling_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mersenne_rolling_hash_table
// Self-checking bench for the mod 2^61-1 rolling hash table.
// A scoreboard class keeps its own prefix hashes, base powers and string length.
// It predicts one result per accepted command item and compares results in
// order. Stimulus has a short directed part, then random command streams under
// several hash bases and handshake idle patterns. A long fill reaches a full
// store, and a long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb_mersenne_rolling_hash_table;
  import mrh_pkg::*;

  localparam int MAX_LEN      = 1024;
  localparam int DRAIN_CYCLES = 40;     // append is the slowest op
  localparam int HOLD_CYCLES  = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_HASH_BASE = {REG_HASH_BASE, 3'b000};

  // Predicts hash table results and checks them in arrival order.
  class hash_table_scoreboard;
    typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic              range_error;
    } hash_result_t;

    logic [HASH_W-1:0] prefix_hash [0:MAX_LEN];
    logic [HASH_W-1:0] base_pow    [0:MAX_LEN];
    int unsigned       str_len;
    logic [HASH_W-1:0] hash_base;
    hash_result_t      expected_q [$];
    int unsigned       mismatches;

    function new();
      prefix_hash[0] = '0;
      base_pow[0]    = POW_ZERO;
      str_len        = 0;
      hash_base      = BASE_RESET;
      mismatches     = 0;
    endfunction

    // s < 2^62 here, so two conditional subtracts land in [0, P)
    static function logic [HASH_W-1:0] mod_fold(input logic [HASH_W+1:0] s);
      if (s >= (HASH_W+2)'(HASH_MOD)) s = s - (HASH_W+2)'(HASH_MOD);
      if (s >= (HASH_W+2)'(HASH_MOD)) s = s - (HASH_W+2)'(HASH_MOD);
      return s[HASH_W-1:0];
    endfunction

    // full 122-bit product, then 2^61 == 1 mod P
    static function logic [HASH_W-1:0] mod_mul(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
      logic [2*HASH_W-1:0] prod;
      prod = (2*HASH_W)'(a) * (2*HASH_W)'(b);
      return mod_fold((HASH_W+2)'(prod[HASH_W-1:0]) +
                      (HASH_W+2)'(prod[2*HASH_W-1:HASH_W]));
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void set_base(input logic [HASH_W-1:0] value);
      hash_base = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted command item to the shadow state.
    function void note_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right);
      hash_result_t      res;
      logic [HASH_W-1:0] b;
      logic [HASH_W-1:0] sub;
      res = '0;
      case (cmd)
        CMD_APPEND: begin
          if (str_len >= MAX_LEN) begin
            res.range_error = 1'b1;
          end else begin
            b = mod_fold((HASH_W+2)'(hash_base));   // all-ones base acts as zero
            res.hash_value = mod_fold((HASH_W+2)'(mod_mul(prefix_hash[str_len], b)) +
                                      (HASH_W+2)'(ch));
            prefix_hash[str_len+1] = res.hash_value;
            base_pow[str_len+1]    = mod_mul(base_pow[str_len], b);
            str_len++;
          end
        end
        CMD_QUERY: begin
          if (left <= right && right <= str_len) begin
            sub = mod_mul(prefix_hash[left], base_pow[right-left]);
            res.hash_value = mod_fold((HASH_W+2)'(prefix_hash[right]) +
                                      (HASH_W+2)'(HASH_MOD - sub));
          end else begin
            res.range_error = 1'b1;
          end
        end
        CMD_CLEAR: str_len = 0;
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    task check_result(input logic [HASH_W-1:0] hash, input logic err);
      hash_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected: hash=%0h err=%0b",
                                  hash, err));
        return;
      end
      want = expected_q.pop_front();
      if (hash !== want.hash_value)
        report_mismatch($sformatf("hash_value got %0h want %0h", hash, want.hash_value));
      if (err !== want.range_error)
        report_mismatch($sformatf("range_error got %0b want %0b", err, want.range_error));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  mrh_in_if  in_ch ();
  mrh_out_if out_ch ();

  hash_table_scoreboard sb;

  // idle odds in percent, changed between phases
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // receiver hold-off: main raises the request, the hold process runs it
  bit hold_request;
  bit hold_active;

  mersenne_rolling_hash_table #(
    .MAX_LENGTH (MAX_LEN)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #1_500_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check every accepted item, then pick next ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.hash_value, out_ch.range_error);
      out_ch.ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver stall, counted here so the sender keeps pushing meanwhile.
  initial begin
    hold_active = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active  = 1'b0;
      end
    end
  end

  // Offer one item (after a random gap) and wait for the handshake.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.char_code   <= ch;
    in_ch.left_index  <= left;
    in_ch.right_index <= right;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(cmd, ch, left, right);
  endtask

  // Mostly well-formed appends and in-range queries; the rest is clears,
  // bad ranges, the unused code and plain noise.
  task automatic send_random_item();
    int unsigned       pick;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
    pick  = $urandom_range(99);
    ch    = CHAR_W'($urandom);
    left  = IDX_W'($urandom);
    right = IDX_W'($urandom);
    if (pick < 50) begin
      send_item(CMD_APPEND, ch, left, right);
    end else if (pick < 80) begin
      right = IDX_W'($urandom_range(sb.str_len));
      left  = IDX_W'($urandom_range(right));
      send_item(CMD_QUERY, ch, left, right);
    end else if (pick < 85) begin
      send_item(CMD_CLEAR, ch, left, right);
    end else if (pick < 93) begin
      if ($urandom_range(1)) begin
        // left past right
        right = IDX_W'($urandom_range(sb.str_len));
        left  = IDX_W'($urandom_range(2047, right + 1));
      end else begin
        // right past the string end
        right = IDX_W'($urandom_range(2047, sb.str_len + 1));
        left  = IDX_W'($urandom_range(right));
      end
      send_item(CMD_QUERY, ch, left, right);
    end else if (pick < 97) begin
      send_item(CMD_UNUSED, ch, left, right);
    end else begin
      send_item(CMD_W'($urandom), ch, left, right);
    end
  endtask

  // Stop offering and wait until every expected result is back and the
  // block has had time to settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; lands when pready is high.
  task automatic write_hash_base(input logic [HASH_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_HASH_BASE;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_base(value);
  endtask

  function automatic logic [HASH_W-1:0] random_base();
    logic [HASH_W-1:0] b;
    b = HASH_W'({$urandom, $urandom});
    if (b == '0) b = 1;
    return b;
  endfunction

  initial begin
    sb                = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_APPEND;
    in_ch.char_code   <= '0;
    in_ch.left_index  <= '0;
    in_ch.right_index <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    hold_request      = 1'b0;
    send_idle_pct     = 33;
    recv_idle_pct     = 80;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset base ---
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'd0);        // empty range, empty string
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'd1);        // past end of empty string
    send_item(CMD_APPEND, 8'h00, 11'd0, 11'd0);
    send_item(CMD_APPEND, 8'hFF, 11'h7FF, 11'h7FF);
    send_item(CMD_APPEND, 8'h61, 11'd0, 11'd0);
    send_item(CMD_APPEND, 8'h80, 11'd0, 11'd0);
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'd4);        // whole string
    send_item(CMD_QUERY, 8'h00, 11'd1, 11'd3);
    send_item(CMD_QUERY, 8'h00, 11'd4, 11'd4);        // empty range at the end
    send_item(CMD_QUERY, 8'h00, 11'd3, 11'd2);        // left past right
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'd5);        // right past length
    send_item(CMD_QUERY, 8'hFF, 11'h7FF, 11'h7FF);
    send_item(CMD_UNUSED, 8'hFF, 11'h7FF, 11'h7FF);
    send_item(CMD_UNUSED, 8'h00, 11'd0, 11'd0);
    send_item(CMD_CLEAR, 8'h00, 11'd0, 11'd0);
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'd1);        // old entries gone
    send_item(CMD_APPEND, 8'hFF, 11'd0, 11'd0);
    send_item(CMD_APPEND, 8'h01, 11'd0, 11'd0);

    // --- base changed mid-string: smallest, largest, all-ones (acts as 0) ---
    drain_results();
    write_hash_base(61'd1);
    send_item(CMD_APPEND, 8'h7F, 11'd0, 11'd0);
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'd3);
    drain_results();
    write_hash_base(HASH_MOD - 61'd1);
    send_item(CMD_APPEND, 8'hA5, 11'd0, 11'd0);
    send_item(CMD_QUERY, 8'h00, 11'd1, 11'd4);
    drain_results();
    write_hash_base(HASH_MOD);
    send_item(CMD_APPEND, 8'h5A, 11'd0, 11'd0);
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'd5);
    send_item(CMD_QUERY, 8'h00, 11'd4, 11'd5);

    // --- random, slow receiver ---
    drain_results();
    write_hash_base(random_base());
    repeat (40) send_random_item();

    // --- random, slow sender ---
    drain_results();
    write_hash_base(random_base());
    send_idle_pct = 80;
    recv_idle_pct = 33;
    repeat (40) send_random_item();

    // --- full throughput: fill the store under a long receiver stall ---
    drain_results();
    write_hash_base(random_base());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    send_item(CMD_CLEAR, 8'h00, 11'd0, 11'd0);
    while (sb.str_len < MAX_LEN / 2)
      send_item(CMD_APPEND, CHAR_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    drain_results();
    write_hash_base(random_base());
    while (sb.str_len < MAX_LEN)
      send_item(CMD_APPEND, CHAR_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    repeat (3) send_item(CMD_APPEND, CHAR_W'($urandom), 11'd0, 11'd0);  // store full
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'(MAX_LEN));
    send_item(CMD_QUERY, 8'h00, 11'(MAX_LEN), 11'(MAX_LEN));
    send_item(CMD_QUERY, 8'h00, 11'd1, 11'(MAX_LEN));
    send_item(CMD_QUERY, 8'h00, 11'd0, 11'(MAX_LEN + 1));
    repeat (20) begin
      send_item(CMD_QUERY, CHAR_W'($urandom), IDX_W'($urandom_range(MAX_LEN / 2)),
                IDX_W'($urandom_range(MAX_LEN, MAX_LEN / 2)));
    end

    // --- random, no idling, one more stall ---
    drain_results();
    hold_request = 1'b1;
    repeat (40) send_random_item();

    drain_results();
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
